### rtl/base64_stream_encoder_defines.svh
// assertion macros for the base64 stream encoder checker
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define B64E_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("base64 encoder check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define B64E_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("base64 encoder check failed");

`endif

### rtl/b64e_pkg.sv
`default_nettype none

package b64e_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] UPPER_BASE = 8'h41;
  localparam logic [7:0] LOWER_BASE = 8'h61;
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] PLUS_CHAR  = 8'h2b;
  localparam logic [7:0] SLASH_CHAR = 8'h2f;
  localparam logic [7:0] PAD_CHAR   = 8'h3d;

  // one 24-bit group waiting to be turned into four characters
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  pad_count;  // trailing '=' characters, 0..2
    logic        fin;        // group closes the message
  } b64e_group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64e_q_status_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v <= 6'd25) begin
      c = UPPER_BASE + w;
    end else if (v <= 6'd51) begin
      c = LOWER_BASE + w - 8'd26;
    end else if (v <= 6'd61) begin
      c = DIGIT_BASE + w - 8'd52;
    end else if (v == 6'd62) begin
      c = PLUS_CHAR;
    end else begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/b64e_if.sv
`default_nettype none

interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       message_last;

  modport source (output valid, output out_char, output run_last, output message_last,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input message_last,
                  output ready);
endinterface

`default_nettype wire

### rtl/b64e_front.sv
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  b64e_byte_if.sink   in_i,
  input  wire logic   q_full_i,
  output b64e_group_t push_data_o,
  output logic        push_o
);

  logic [15:0] pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  always_comb begin
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    push_o      = 1'b0;
    push_data_o = '0;
    if (cnt_q >= 2'd2) begin
      push_data_o.group     = {pend_q, in_i.data_byte};
      push_data_o.pad_count = 2'd0;
    end else if (cnt_q == 2'd1) begin
      push_data_o.group     = {pend_q[7:0], in_i.data_byte, 8'h00};
      push_data_o.pad_count = 2'd1;
    end else begin
      push_data_o.group     = {in_i.data_byte, 16'h0000};
      push_data_o.pad_count = 2'd2;
    end
    push_data_o.fin = in_i.final_byte;
    if (accept) begin
      if (cnt_q >= 2'd2 || in_i.final_byte) begin
        push_o = 1'b1;
        cnt_d  = 2'd0;
      end else begin
        pend_d = {pend_q[7:0], in_i.data_byte};
        cnt_d  = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/b64e_fifo.sv
`default_nettype none

module b64e_fifo
  import b64e_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire b64e_group_t  push_data_i,
  input  wire logic         pop_i,
  output b64e_group_t       pop_data_o,
  output b64e_q_status_t    status_o
);

  b64e_group_t       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QPTR_W'(1);
    end
    return r;
  endfunction

  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/b64e_back.sv
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire b64e_group_t    pop_data_i,
  input  wire b64e_q_status_t q_status_i,
  output logic                pop_o,
  b64e_char_if.source         out_o
);

  b64e_group_t cur_q;
  logic        active_q;
  logic [1:0]  idx_q;
  logic        out_valid_q;
  logic [7:0]  out_char_q;
  logic        run_last_q, message_last_q;

  logic        load_out;
  logic        group_done;
  logic [5:0]  sextet;
  logic [2:0]  pos_sum;
  logic [7:0]  next_char;

  assign load_out   = active_q && (!out_valid_q || out_o.ready);
  assign group_done = load_out && (idx_q == 2'd3);
  assign pop_o      = (!active_q || group_done) && !q_status_i.empty;

  always_comb begin
    case (idx_q)
      2'd0:    sextet = cur_q.group[23:18];
      2'd1:    sextet = cur_q.group[17:12];
      2'd2:    sextet = cur_q.group[11:6];
      default: sextet = cur_q.group[5:0];
    endcase
    // a position at or beyond four minus the pad count is an '='
    pos_sum   = {1'b0, idx_q} + {1'b0, cur_q.pad_count};
    next_char = (pos_sum < 3'd4) ? sextet_char(sextet) : PAD_CHAR;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= pop_data_i;
    end
    if (load_out) begin
      out_char_q     <= next_char;
      run_last_q     <= (idx_q == 2'd3);
      message_last_q <= (idx_q == 2'd3) && cur_q.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        idx_q <= '0;
      end else if (load_out) begin
        idx_q <= idx_q + 2'd1;
      end
      if (pop_o) begin
        active_q <= 1'b1;
      end else if (group_done) begin
        active_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_char     = out_char_q;
  assign out_o.run_last     = run_last_q;
  assign out_o.message_last = message_last_q;

endmodule

`default_nettype wire

### rtl/base64_stream_encoder.sv
// Streaming base64 encoder, standard alphabet with '=' padding. Message bytes come
// in one beat each on in_i, the last one flagged by final_byte; characters go out
// one beat each on out_o. Every third byte yields four characters, and the final
// byte flushes a partial group of one or two bytes as two or three characters plus
// padding, so each group is always four characters. run_last marks the fourth
// character of a group and message_last the last character of the message. The
// input takes a byte every cycle while the two-entry group queue has room; the
// output emits one character per cycle while out_o is ready, so a long message
// settles at four characters per three bytes, a rate set by the single character
// output port. A completing byte reaches the output via the queue, the back's group
// register and the output register. An empty message cannot be expressed.
`default_nettype none

module base64_stream_encoder
  import b64e_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  b64e_byte_if.sink    in_i,
  b64e_char_if.source  out_o
);

  // front to queue: a completed or flushed group
  b64e_group_t    push_data;
  logic           push;

  // queue to back
  b64e_group_t    pop_data;
  logic           pop;
  b64e_q_status_t q_status;

  // front: gathers bytes into groups, holds the pending bytes
  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_full_i    (q_status.full),
    .push_data_o (push_data),
    .push_o      (push)
  );

  // short queue so the byte side keeps going while characters drain
  b64e_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // back: turns one group into four characters, one per cycle while out_o is ready, into the output register
  b64e_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_data_i (pop_data),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

### rtl/b64e_checker.sv
`default_nettype none
`include "base64_stream_encoder_defines.svh"

module b64e_checker
  import b64e_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_char_i,
  input wire logic       run_last_i,
  input wire logic       message_last_i
);

  logic [1:0] char_cnt_q;
  logic       out_beat;
  logic [9:0] out_payload;

  assign out_beat    = out_valid_i && out_ready_i;
  assign out_payload = {out_char_i, run_last_i, message_last_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_cnt_q <= '0;
    end else if (out_beat) begin
      char_cnt_q <= char_cnt_q + 2'd1;
    end
  end

  // stalled character holds
  `B64E_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_payload))
  // run_last exactly on every fourth character beat
  `B64E_ASSERT_NOW(a_group_of_four, out_beat, run_last_i == (char_cnt_q == 2'd3))
  // message end only closes a group
  `B64E_ASSERT_NOW(a_msg_last_in_run, out_valid_i && message_last_i, run_last_i)
  // a padded group is always the final one
  `B64E_ASSERT_NOW(a_pad_is_final, out_beat && run_last_i && out_char_i == PAD_CHAR, message_last_i)

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_char_i     (out_o.out_char),
  .run_last_i     (out_o.run_last),
  .message_last_i (out_o.message_last)
);

`default_nettype wire
